// ----- hdl/mfs_pkg.sv -----
`default_nettype none
package mfs_pkg;

   // store geometry
   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VAL_W   = 30;
   localparam int STAT_W  = 2;

   // reduction grouping: cells are summed and searched eight at a time
   localparam int GROUP   = 8;
   localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;
   localparam int PAD_W   = NGROUPS * GROUP;
   localparam int GCNT_W  = $clog2(GROUP + 1);
   localparam int GIDX_W  = $clog2(GROUP);

   // operation codes
   localparam logic FN_PUSH = 1'b0;
   localparam logic FN_POP  = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic             func;
      logic [VAL_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  pop_value;
      logic [STAT_W-1:0] status;
   } rsp_type;

   // per-group partial results of the match and level searches
   typedef struct packed {
      logic [NGROUPS-1:0][GCNT_W-1:0] match_cnt;
      logic [NGROUPS-1:0][GCNT_W-1:0] hit_cnt;
      logic [NGROUPS-1:0]             hit_any;
      logic [NGROUPS-1:0][GIDX_W-1:0] hit_idx;
   } red_type;

endpackage
`default_nettype wire

// ----- hdl/mfs_cell.sv -----
`default_nettype none
module mfs_cell (
   input  wire                       clock,
   input  wire                       capture,
   input  wire [mfs_pkg::VAL_W-1:0]  key,
   input  wire [mfs_pkg::CNT_W-1:0]  top_level,
   input  wire                       occupied,
   input  wire                       load,
   input  wire [mfs_pkg::VAL_W-1:0]  load_value,
   input  wire [mfs_pkg::CNT_W-1:0]  load_level,
   input  wire                       shift,
   input  wire [mfs_pkg::VAL_W-1:0]  upper_value,
   input  wire [mfs_pkg::CNT_W-1:0]  upper_level,
   output logic [mfs_pkg::VAL_W-1:0] value,
   output logic [mfs_pkg::CNT_W-1:0] level,
   output logic                      match,
   output logic                      hit
);
   import mfs_pkg::*;

   logic [VAL_W-1:0] value_ff;
   logic [CNT_W-1:0] level_ff;
   logic             match_ff;
   logic             hit_ff;

   // hold the entry; take a new push or close the gap from above
   always_ff @(posedge clock) begin
      priority if (load) begin
         value_ff <= load_value;
         level_ff <= load_level;
      end else if (shift) begin
         value_ff <= upper_value;
         level_ff <= upper_level;
      end else begin
         value_ff <= value_ff;
         level_ff <= level_ff;
      end
   end

   // compare against the incoming beat and the current top level
   always_ff @(posedge clock) begin
      if (capture) begin
         match_ff <= occupied && (value_ff == key);
         hit_ff   <= occupied && (level_ff == top_level);
      end
   end

   assign value = value_ff;
   assign level = level_ff;
   assign match = match_ff;
   assign hit   = hit_ff;

endmodule
`default_nettype wire

// ----- hdl/mfs_reduce.sv -----
`default_nettype none
module mfs_reduce (
   input  wire                        clock,
   input  wire [mfs_pkg::DEPTH-1:0]   match,
   input  wire [mfs_pkg::DEPTH-1:0]   hit,
   output mfs_pkg::red_type           red
);
   import mfs_pkg::*;

   logic [PAD_W-1:0] match_pad;
   logic [PAD_W-1:0] hit_pad;
   red_type          red_in;
   red_type          red_ff;

   assign match_pad = PAD_W'(match);
   assign hit_pad   = PAD_W'(hit);

   // count matches and levels per group, find the highest hit per group
   always_comb begin
      red_in = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         for (int b = 0; b < GROUP; b++) begin
            red_in.match_cnt[g] = red_in.match_cnt[g]
                                  + GCNT_W'(match_pad[g*GROUP+b]);
            red_in.hit_cnt[g]   = red_in.hit_cnt[g]
                                  + GCNT_W'(hit_pad[g*GROUP+b]);
            if (hit_pad[g*GROUP+b]) begin
               red_in.hit_any[g] = 1'b1;
               red_in.hit_idx[g] = GIDX_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
   end

   assign red = red_ff;

endmodule
`default_nettype wire

// ----- hdl/max_frequency_stack_unit.sv -----
`default_nettype none
// Channel   Ports                 Handshake          Beat
// request   start, req_payload    start && !busy     func, push_value
// response  rsp_strobe, rsp_pay.  rsp_strobe, 1 cyc  pop_value, status
//
// Each beat runs as compare in every cell, grouped count and priority
// search, then update of the cell row; the response shows in the cycle
// after, when busy is already low again, and no new beat is taken before.
// The group reduction of the match and level vectors is registered.
// Synchronous reset clears the state, fill count, top level and strobe; no sweep.
// The receiver cannot stall: each response is shown for one cycle only.
module max_frequency_stack_unit (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire mfs_pkg::req_type req_payload,
   output logic              busy,
   output logic              rsp_strobe,
   output mfs_pkg::rsp_type  rsp_payload
);
   import mfs_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_REDUCE = 2'd1;
   localparam logic [1:0] S_APPLY  = 2'd2;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] top_ff;
   logic [CNT_W-1:0] top_in;
   logic             rsp_strobe_ff;
   logic             rsp_strobe_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   req_type          op_ff;

   logic             accept;
   logic [DEPTH-1:0] occupied;
   logic [DEPTH-1:0] load;
   logic [DEPTH-1:0] shift;
   logic [DEPTH-1:0] match;
   logic [DEPTH-1:0] hit;
   logic [VAL_W-1:0] cell_value [DEPTH];
   logic [CNT_W-1:0] cell_level [DEPTH];
   red_type          red;

   logic [CNT_W-1:0] match_sum;
   logic [CNT_W-1:0] hit_sum;
   logic             found;
   logic [IDX_W-1:0] hit_pick;
   logic [IDX_W-1:0] pick;
   logic [CNT_W-1:0] new_level;
   logic             do_push;
   logic             do_pop;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // occupancy, write and shift enables for the cell row
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occupied[i] = (CNT_W'(i) < count_ff);
         load[i]     = do_push && (count_ff == CNT_W'(i));
         shift[i]    = do_pop && (IDX_W'(i) >= pick);
      end
   end

   // row of cells, each fed by its upper neighbour
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VAL_W-1:0] upper_value;
      logic [CNT_W-1:0] upper_level;
      if (i == DEPTH - 1) begin : g_last
         assign upper_value = '0;
         assign upper_level = '0;
      end else begin : g_link
         assign upper_value = cell_value[i+1];
         assign upper_level = cell_level[i+1];
      end
      mfs_cell u_cell (
         .clock       (clock),
         .capture     (accept),
         .key         (req_payload.push_value),
         .top_level   (top_ff),
         .occupied    (occupied[i]),
         .load        (load[i]),
         .load_value  (op_ff.push_value),
         .load_level  (new_level),
         .shift       (shift[i]),
         .upper_value (upper_value),
         .upper_level (upper_level),
         .value       (cell_value[i]),
         .level       (cell_level[i]),
         .match       (match[i]),
         .hit         (hit[i])
      );
   end

   mfs_reduce u_reduce (
      .clock (clock),
      .match (match),
      .hit   (hit),
      .red   (red)
   );

   // finish the sums and pick the highest group that holds a hit
   always_comb begin
      match_sum = '0;
      hit_sum   = '0;
      found     = 1'b0;
      hit_pick  = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         match_sum = match_sum + CNT_W'(red.match_cnt[g]);
         hit_sum   = hit_sum + CNT_W'(red.hit_cnt[g]);
         if (red.hit_any[g]) begin
            found    = 1'b1;
            hit_pick = IDX_W'(g * GROUP + int'(red.hit_idx[g]));
         end
      end
      pick      = found ? hit_pick : IDX_W'(count_ff - CNT_W'(1));
      new_level = match_sum + CNT_W'(1);
   end

   assign do_push = (state_ff == S_APPLY) && (op_ff.func == FN_PUSH)
                    && (count_ff != CNT_W'(DEPTH));
   assign do_pop  = (state_ff == S_APPLY) && (op_ff.func == FN_POP)
                    && (count_ff != '0);

   // sequence the beat and build the response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_REDUCE;
         end
         S_REDUCE: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in          = S_IDLE;
            rsp_strobe_in     = 1'b1;
            rsp_in.pop_value  = '0;
            rsp_in.status     = ST_OK;
            if (op_ff.func == FN_PUSH) begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  if (new_level > top_ff) top_in = new_level;
               end
            end else begin
               if (count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.pop_value = cell_value[pick];
                  count_in         = count_ff - CNT_W'(1);
                  if (found && (hit_sum < CNT_W'(2)) && (top_ff != '0)) begin
                     top_in = top_ff - CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         top_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         top_ff        <= top_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) op_ff <= req_payload;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while a beat is in flight");
   a_beat_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("accepted beat gave no response");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");
   a_top_le_count: assert property (@(posedge clock) disable iff (reset)
      top_ff <= count_ff)
      else $error("top level above fill count");
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status == ST_FULL) |-> count_ff == CNT_W'(DEPTH))
      else $error("full flagged on a store with room");
`endif

endmodule
`default_nettype wire
